>>> hw/rtl/pec_pkg.sv
// Shared types and codes for the priority/expiry LRU cache.
// No dependencies; used by pec_mem and priority_expiry_lru_cache.
package pec_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam logic [1:0] ACT_GET    = 2'd0;
    localparam logic [1:0] ACT_SET    = 2'd1;
    localparam logic [1:0] ACT_RESIZE = 2'd2;

    localparam logic [1:0] KIND_GET   = 2'd0;
    localparam logic [1:0] KIND_EVICT = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;

    // One cache slot as it sits in the slot memory.
    typedef struct packed {
        logic [31:0] key;
        logic [31:0] data;
        logic [15:0] prio;
        logic [31:0] expiry;
        logic [31:0] stamp;
    } entry_t;

    // One result word.
    typedef struct packed {
        logic [1:0]  kind;
        logic        hit;
        logic [31:0] data;
        logic [31:0] vkey;
        logic        vexp;
        logic        last;
    } res_t;

endpackage

>>> hw/rtl/priority_expiry_lru_cache.sv
// Top level of the priority/expiry LRU cache: sequencer, valid bits, staging slot.
// Depends on pec_pkg and pec_mem.
//
//  channel  | handshake        | words
//  ---------+------------------+-----------------------------------------------
//  command  | start / busy     | action, now, key, data_in, prio, expire_in, new_limit
//  result   | strobe (1 cycle) | kind, hit, data_out, victim_key, victim_expired, last
//
// Every memory slot is visited once per scan, one a cycle through the single read
// port. A get takes one scan; a set one scan plus one per eviction; a resize one
// scan per eviction. When the use counter wraps, stamps are renumbered by repeated
// scans before the word goes on. Reset empties the cache at once; busy is high
// while a word is in work and the receiver cannot stall results.
module priority_expiry_lru_cache #(
    parameter int CAPACITY = pec_pkg::CAPACITY_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         action,
    input  logic [31:0]        now,
    input  logic [31:0]        key,
    input  logic signed [31:0] data_in,
    input  logic [15:0]        prio,
    input  logic [15:0]        expire_in,
    input  logic [4:0]         new_limit,
    output logic               strobe,
    output logic [1:0]         kind,
    output logic               hit,
    output logic signed [31:0] data_out,
    output logic [31:0]        victim_key,
    output logic               victim_expired,
    output logic               last
);
    import pec_pkg::*;

    localparam int IW  = $clog2(CAPACITY);
    localparam int SCW = $clog2(CAPACITY + 1);
    localparam int CW  = $clog2(CAPACITY + 2);
    localparam int LW  = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_FIND, S_FDONE, S_STAMP, S_RSCAN, S_RDEC,
        S_COMMIT, S_ECHK, S_ESCAN, S_EPICK
    } state_t;

    state_t           state_reg;
    logic [SCW-1:0]   cnt_reg;
    logic [CAPACITY-1:0] valid_reg;
    logic [CAPACITY-1:0] mark_reg;
    logic [CW-1:0]    count_reg;
    logic [31:0]      use_ctr_reg;
    logic [LW-1:0]    limit_reg;

    logic [1:0]       act_reg;
    logic [31:0]      now_reg;
    logic [31:0]      key_reg;
    logic [31:0]      data_reg;
    logic [15:0]      prio_reg;
    logic [31:0]      exp_reg;
    logic [31:0]      stamp_reg;

    logic             found_reg;
    logic [IW-1:0]    fidx_reg;
    entry_t           fent_reg;
    logic             free_reg;
    logic [IW-1:0]    freeidx_reg;

    logic             rn_have_reg;
    logic [IW-1:0]    rn_idx_reg;
    entry_t           rn_ent_reg;
    logic [CW-1:0]    rank_reg;

    logic             stage_valid_reg;
    entry_t           stage_reg;

    logic             ex_have_reg;
    logic [IW-1:0]    ex_idx_reg;
    logic [31:0]      ex_key_reg;
    logic [31:0]      ex_stamp_reg;
    logic             pr_have_reg;
    logic [IW-1:0]    pr_idx_reg;
    logic [31:0]      pr_key_reg;
    logic [31:0]      pr_stamp_reg;
    logic [15:0]      pr_prio_reg;

    logic             strobe_reg;
    res_t             res_reg;

    logic             mem_we;
    logic [IW-1:0]    mem_waddr;
    entry_t           mem_wdata;
    logic [IW-1:0]    mem_raddr;
    entry_t           rdata;

    logic [IW-1:0]    eidx;
    logic             ev_valid;
    logic [32:0]      exp_sum;
    logic [31:0]      exp_sat;
    logic             over_limit;
    logic             stg_exp;
    logic             vic_stg;
    logic             vic_exp;
    logic [IW-1:0]    vic_idx;
    logic [31:0]      vic_key;
    entry_t           new_ent;

    pec_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rdata)
    );

    assign busy           = (state_reg != S_IDLE);
    assign strobe         = strobe_reg;
    assign kind           = res_reg.kind;
    assign hit            = res_reg.hit;
    assign data_out       = $signed(res_reg.data);
    assign victim_key     = res_reg.vkey;
    assign victim_expired = res_reg.vexp;
    assign last           = res_reg.last;

    always_comb
    begin
        // The read issued for slot k returns while the counter stands at k+1.
        mem_raddr = (cnt_reg < SCW'(CAPACITY)) ? IW'(cnt_reg) : '0;
        eidx      = IW'(cnt_reg - SCW'(1));
        ev_valid  = (cnt_reg != '0) && valid_reg[eidx];

        exp_sum = {1'b0, now} + {17'd0, expire_in};
        exp_sat = exp_sum[32] ? '1 : exp_sum[31:0];

        over_limit = (int'(count_reg) + int'(stage_valid_reg)) > int'(limit_reg);

        new_ent.key    = key_reg;
        new_ent.data   = data_reg;
        new_ent.prio   = prio_reg;
        new_ent.expiry = exp_reg;
        new_ent.stamp  = stamp_reg;

        // The staging slot is judged last, so it wins only on a strict improvement.
        stg_exp = stage_valid_reg && (stage_reg.expiry <= now_reg);
        if (ex_have_reg || stg_exp)
        begin
            vic_exp = 1'b1;
            vic_stg = stg_exp && (!ex_have_reg || stage_reg.stamp < ex_stamp_reg);
            vic_idx = ex_idx_reg;
            vic_key = vic_stg ? stage_reg.key : ex_key_reg;
        end
        else
        begin
            vic_exp = 1'b0;
            vic_stg = stage_valid_reg && (!pr_have_reg || stage_reg.prio < pr_prio_reg
                      || (stage_reg.prio == pr_prio_reg && stage_reg.stamp < pr_stamp_reg));
            vic_idx = pr_idx_reg;
            vic_key = vic_stg ? stage_reg.key : pr_key_reg;
        end

        mem_we    = 1'b0;
        mem_waddr = fidx_reg;
        mem_wdata = fent_reg;
        case (state_reg)
            S_RDEC:
            begin
                mem_we          = rn_have_reg;
                mem_waddr       = rn_idx_reg;
                mem_wdata       = rn_ent_reg;
                mem_wdata.stamp = 32'(rank_reg);
            end
            S_COMMIT:
            begin
                if (act_reg == ACT_GET)
                begin
                    mem_we          = 1'b1;
                    mem_wdata.stamp = stamp_reg;
                end
                else
                begin
                    mem_we    = found_reg || free_reg;
                    mem_waddr = found_reg ? fidx_reg : freeidx_reg;
                    mem_wdata = new_ent;
                end
            end
            S_EPICK:
            begin
                mem_we    = !vic_stg && stage_valid_reg;
                mem_waddr = vic_idx;
                mem_wdata = stage_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            cnt_reg         <= '0;
            valid_reg       <= '0;
            mark_reg        <= '0;
            count_reg       <= '0;
            use_ctr_reg     <= '0;
            limit_reg       <= LW'(CAPACITY);
            found_reg       <= 1'b0;
            free_reg        <= 1'b0;
            rn_have_reg     <= 1'b0;
            rank_reg        <= '0;
            stage_valid_reg <= 1'b0;
            ex_have_reg     <= 1'b0;
            pr_have_reg     <= 1'b0;
            strobe_reg      <= 1'b0;
            res_reg         <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        act_reg   <= action;
                        now_reg   <= now;
                        key_reg   <= key;
                        data_reg  <= $unsigned(data_in);
                        prio_reg  <= prio;
                        exp_reg   <= exp_sat;
                        found_reg <= 1'b0;
                        free_reg  <= 1'b0;
                        cnt_reg   <= '0;
                        case (action)
                            ACT_GET, ACT_SET:
                            begin
                                state_reg <= S_FIND;
                            end
                            ACT_RESIZE:
                            begin
                                limit_reg <= (int'(new_limit) > CAPACITY) ? LW'(CAPACITY)
                                                                          : LW'(new_limit);
                                state_reg <= S_ECHK;
                            end
                            default:
                            begin
                                strobe_reg <= 1'b1;
                                res_reg    <= '{KIND_DONE, 1'b0, 32'd0, 32'd0, 1'b0, 1'b1};
                            end
                        endcase
                    end
                end
                S_FIND:
                begin
                    if (ev_valid && !found_reg && rdata.key == key_reg)
                    begin
                        found_reg <= 1'b1;
                        fidx_reg  <= eidx;
                        fent_reg  <= rdata;
                    end
                    if (cnt_reg != '0 && !valid_reg[eidx] && !free_reg)
                    begin
                        free_reg    <= 1'b1;
                        freeidx_reg <= eidx;
                    end
                    if (cnt_reg == SCW'(CAPACITY))
                    begin
                        state_reg <= S_FDONE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + SCW'(1);
                    end
                end
                S_FDONE:
                begin
                    if (act_reg == ACT_GET && (!found_reg || fent_reg.expiry <= now_reg))
                    begin
                        if (found_reg)
                        begin
                            valid_reg[fidx_reg] <= 1'b0;
                            count_reg           <= count_reg - CW'(1);
                        end
                        strobe_reg <= 1'b1;
                        res_reg    <= '{KIND_GET, 1'b0, 32'd0, 32'd0, 1'b0, 1'b1};
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_STAMP;
                    end
                end
                S_STAMP:
                begin
                    if (use_ctr_reg == '1)
                    begin
                        mark_reg    <= '0;
                        rank_reg    <= '0;
                        rn_have_reg <= 1'b0;
                        cnt_reg     <= '0;
                        state_reg   <= S_RSCAN;
                    end
                    else
                    begin
                        stamp_reg   <= use_ctr_reg;
                        use_ctr_reg <= use_ctr_reg + 32'd1;
                        state_reg   <= S_COMMIT;
                    end
                end
                S_RSCAN:
                begin
                    // Find the oldest entry not yet renumbered.
                    if (ev_valid && !mark_reg[eidx]
                        && (!rn_have_reg || rdata.stamp < rn_ent_reg.stamp))
                    begin
                        rn_have_reg <= 1'b1;
                        rn_idx_reg  <= eidx;
                        rn_ent_reg  <= rdata;
                    end
                    if (cnt_reg == SCW'(CAPACITY))
                    begin
                        state_reg <= S_RDEC;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + SCW'(1);
                    end
                end
                S_RDEC:
                begin
                    if (rn_have_reg)
                    begin
                        mark_reg[rn_idx_reg] <= 1'b1;
                        rank_reg             <= rank_reg + CW'(1);
                        rn_have_reg          <= 1'b0;
                        cnt_reg              <= '0;
                        state_reg            <= S_RSCAN;
                    end
                    else
                    begin
                        use_ctr_reg <= 32'(rank_reg);
                        state_reg   <= S_STAMP;
                    end
                end
                S_COMMIT:
                begin
                    if (act_reg == ACT_GET)
                    begin
                        strobe_reg <= 1'b1;
                        res_reg    <= '{KIND_GET, 1'b1, fent_reg.data, 32'd0, 1'b0, 1'b1};
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        if (!found_reg && free_reg)
                        begin
                            valid_reg[freeidx_reg] <= 1'b1;
                            count_reg              <= count_reg + CW'(1);
                        end
                        else if (!found_reg)
                        begin
                            stage_reg       <= new_ent;
                            stage_valid_reg <= 1'b1;
                        end
                        state_reg <= S_ECHK;
                    end
                end
                S_ECHK:
                begin
                    if (over_limit)
                    begin
                        cnt_reg     <= '0;
                        ex_have_reg <= 1'b0;
                        pr_have_reg <= 1'b0;
                        state_reg   <= S_ESCAN;
                    end
                    else
                    begin
                        strobe_reg <= 1'b1;
                        res_reg    <= '{KIND_DONE, 1'b0, 32'd0, 32'd0, 1'b0, 1'b1};
                        state_reg  <= S_IDLE;
                    end
                end
                S_ESCAN:
                begin
                    if (ev_valid)
                    begin
                        if (rdata.expiry <= now_reg
                            && (!ex_have_reg || rdata.stamp < ex_stamp_reg))
                        begin
                            ex_have_reg  <= 1'b1;
                            ex_idx_reg   <= eidx;
                            ex_key_reg   <= rdata.key;
                            ex_stamp_reg <= rdata.stamp;
                        end
                        if (!pr_have_reg || rdata.prio < pr_prio_reg
                            || (rdata.prio == pr_prio_reg && rdata.stamp < pr_stamp_reg))
                        begin
                            pr_have_reg  <= 1'b1;
                            pr_idx_reg   <= eidx;
                            pr_key_reg   <= rdata.key;
                            pr_stamp_reg <= rdata.stamp;
                            pr_prio_reg  <= rdata.prio;
                        end
                    end
                    if (cnt_reg == SCW'(CAPACITY))
                    begin
                        state_reg <= S_EPICK;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + SCW'(1);
                    end
                end
                S_EPICK:
                begin
                    strobe_reg <= 1'b1;
                    res_reg    <= '{KIND_EVICT, 1'b0, 32'd0, vic_key, vic_exp, 1'b0};
                    // A stored victim hands its slot to the staged entry, if any.
                    if (vic_stg || stage_valid_reg)
                    begin
                        stage_valid_reg <= 1'b0;
                    end
                    else
                    begin
                        valid_reg[vic_idx] <= 1'b0;
                        count_reg          <= count_reg - CW'(1);
                    end
                    state_reg <= S_ECHK;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> hw/rtl/pec_mem.sv
// Slot memory: one write port, one read port with registered read data.
// Depends on pec_pkg for the entry type.
module pec_mem #(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  pec_pkg::entry_t          wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output pec_pkg::entry_t          rdata
);
    import pec_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
